// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check at every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Check at every rising edge outside reset
`define ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== design/cfp_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the frame parser.
// No dependencies; imported by cfp_front, cfp_queue, cfp_back and the top level.
package cfp_pkg;

    // Reset value of the expected header byte
    localparam logic [7:0] HEADER_RESET = 8'd250;

    // CRC-16 constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8005;

    // Byte count below which a buffer is always too short
    localparam logic [2:0] MIN_FRAME_BYTES = 3'd6;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_HDR   = 2'd2;
    localparam logic [1:0] ST_CRC_ERR   = 2'd3;

    // Role of one received byte within its frame
    typedef enum logic [2:0] {
        K_HDR,
        K_TYPE,
        K_LEN,
        K_PAYLOAD,
        K_CRC_LO,
        K_CRC_HI,
        K_SKIP
    } kind_t;

    // Classified byte passed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
        logic       short_buf;
        logic       incomplete;
        logic       hdr_bad;
    } qword_t;

    // One result word
    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        logic [7:0] msg_type;
        logic [1:0] status;
    } result_t;

    // CRC-16, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/cfp_front.sv =====
// Front end: accepts bytes, tracks frame position and classifies each byte.
// Depends on cfp_pkg; feeds cfp_queue.
module cfp_front
    import cfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    input  logic       buffer_end,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       q_full,
    output logic       q_push,
    output qword_t     q_word
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  seen_reg, seen_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  header_value_reg;
    kind_t       kind;

    assign full   = q_full;
    assign q_push = push && !q_full;

    // Classify the byte and step the frame position
    always_comb
    begin
        phase_next  = phase_reg;
        len_lo_next = len_lo_reg;
        left_next   = left_reg;
        kind        = K_SKIP;
        unique case (phase_reg)
            PH_HDR:
            begin
                kind       = K_HDR;
                phase_next = PH_TYPE;
            end
            PH_TYPE:
            begin
                kind       = K_TYPE;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                kind        = K_LEN;
                len_lo_next = rx_byte;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                kind       = K_LEN;
                left_next  = {rx_byte, len_lo_reg};
                phase_next = ({rx_byte, len_lo_reg} == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                kind      = K_PAYLOAD;
                left_next = left_reg - 16'd1;
                if (left_reg == 16'd1)
                begin
                    phase_next = PH_CRC_LO;
                end
            end
            PH_CRC_LO:
            begin
                kind       = K_CRC_LO;
                phase_next = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                kind       = K_CRC_HI;
                phase_next = PH_DONE;
            end
            PH_DONE:
            begin
                kind = K_SKIP;
            end
        endcase
        seen_next = (seen_reg < MIN_FRAME_BYTES) ? seen_reg + 3'd1 : seen_reg;
    end

    // Build the queue word
    always_comb
    begin
        q_word.kind       = kind;
        q_word.data       = rx_byte;
        q_word.last       = buffer_end;
        q_word.short_buf  = (seen_next < MIN_FRAME_BYTES);
        q_word.incomplete = (phase_next != PH_DONE);
        q_word.hdr_bad    = (rx_byte != header_value_reg);
    end

    // Hold parse position; drop back to header on buffer end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR;
            seen_reg         <= 3'd0;
            len_lo_reg       <= 8'd0;
            left_reg         <= 16'd0;
            header_value_reg <= HEADER_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                header_value_reg <= cfg_wdata;
            end
            if (q_push)
            begin
                if (buffer_end)
                begin
                    phase_reg  <= PH_HDR;
                    seen_reg   <= 3'd0;
                    len_lo_reg <= 8'd0;
                    left_reg   <= 16'd0;
                end
                else
                begin
                    phase_reg  <= phase_next;
                    seen_reg   <= seen_next;
                    len_lo_reg <= len_lo_next;
                    left_reg   <= left_next;
                end
            end
        end
    end

endmodule

// ===== design/cfp_queue.sv =====
// Short FIFO of classified byte words between front and back.
// Depends on cfp_pkg.
module cfp_queue
    import cfp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  qword_t wr_word,
    output logic   q_full,
    input  logic   rd_en,
    output logic   q_empty,
    output qword_t rd_word
);

    qword_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_word = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

// ===== design/cfp_back.sv =====
// Back end: runs the CRC, keeps type and received CRC, and issues result words.
// Depends on cfp_pkg; drains cfp_queue.
module cfp_back
    import cfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  qword_t  q_word,
    output logic    q_pop,
    input  logic    pop,
    output logic    out_valid,
    output result_t out_word
);

    logic [15:0] crc_reg, crc_next, crc_step;
    logic [15:0] recv_reg, recv_next;
    logic [7:0]  type_reg, type_next;
    logic        hdr_bad_reg, hdr_bad_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        pend_valid_reg, pend_valid_next;
    result_t     pend_reg, pend_next;
    logic        slot_free;
    logic        crc_on;
    logic [1:0]  st_code;
    result_t     st_word;

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign slot_free = !out_valid_reg || pop;

    // Work out the effect of the head word
    always_comb
    begin
        crc_on = (q_word.kind == K_HDR) || (q_word.kind == K_TYPE) ||
                 (q_word.kind == K_LEN) || (q_word.kind == K_PAYLOAD);
        crc_step     = crc16_byte(crc_reg, q_word.data);
        crc_next     = crc_on ? crc_step : crc_reg;
        type_next    = (q_word.kind == K_TYPE) ? q_word.data : type_reg;
        hdr_bad_next = (q_word.kind == K_HDR) ? q_word.hdr_bad : hdr_bad_reg;
        recv_next    = recv_reg;
        if (q_word.kind == K_CRC_LO)
        begin
            recv_next = {8'd0, q_word.data};
        end
        else if (q_word.kind == K_CRC_HI)
        begin
            recv_next = {q_word.data, recv_reg[7:0]};
        end

        priority if (q_word.short_buf)
        begin
            st_code = ST_SHORT;
        end
        else if (hdr_bad_next)
        begin
            st_code = ST_BAD_HDR;
        end
        else if (q_word.incomplete)
        begin
            st_code = ST_SHORT;
        end
        else if (recv_next != crc_next)
        begin
            st_code = ST_CRC_ERR;
        end
        else
        begin
            st_code = ST_OK;
        end

        st_word.is_status    = 1'b1;
        st_word.payload_byte = 8'd0;
        st_word.msg_type     = type_next;
        st_word.status       = st_code;
    end

    // Issue results: pending status first, then the head word
    always_comb
    begin
        q_pop           = 1'b0;
        out_valid_next  = out_valid_reg && !pop;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (pend_valid_reg)
        begin
            if (slot_free)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
        end
        else if (!q_empty && slot_free)
        begin
            q_pop = 1'b1;
            if (q_word.kind == K_PAYLOAD)
            begin
                out_valid_next        = 1'b1;
                out_next.is_status    = 1'b0;
                out_next.payload_byte = q_word.data;
                out_next.msg_type     = type_next;
                out_next.status       = ST_OK;
                if (q_word.last)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = st_word;
                end
            end
            else if (q_word.last)
            begin
                out_valid_next = 1'b1;
                out_next       = st_word;
            end
        end
    end

    // Hold frame state and handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= CRC_INIT;
            recv_reg       <= 16'd0;
            type_reg       <= 8'd0;
            hdr_bad_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (q_pop)
            begin
                if (q_word.last)
                begin
                    crc_reg     <= CRC_INIT;
                    recv_reg    <= 16'd0;
                    type_reg    <= 8'd0;
                    hdr_bad_reg <= 1'b0;
                end
                else
                begin
                    crc_reg     <= crc_next;
                    recv_reg    <= recv_next;
                    type_reg    <= type_next;
                    hdr_bad_reg <= hdr_bad_next;
                end
            end
        end
    end

    // Hold result payloads
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

endmodule

// ===== design/crc16_frame_parser_unit.sv =====
// Top level of the length-prefixed CRC-16 frame parser.
// Depends on cfp_pkg, cfp_front, cfp_queue and cfp_back.
//
//  channel   handshake           payload
//  -------   ---------           -------
//  input     push / full         rx_byte, buffer_end
//  result    empty / pop         is_status, payload_byte, msg_type, status
//  config    cfg_we              cfg_wdata (expected header byte)
//
// One byte is taken per cycle while full is low; the CRC byte update in the back end sets that figure.
// A byte that carries both the last payload byte and buffer end yields two results,
// the payload word and then its status word, from the single output register.
// A result reaches the ports at the earliest through the queue write and then the output register.
// Reset clears the parse state, the queue and the output; the header register returns to 250.
// A stalled result side fills the four-word queue, after which full holds off the input.
module crc16_frame_parser_unit
    import cfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    input  logic       buffer_end,
    output logic       empty,
    input  logic       pop,
    output logic       is_status,
    output logic [7:0] payload_byte,
    output logic [7:0] msg_type,
    output logic [1:0] status,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    qword_t  q_in;
    qword_t  q_out;
    logic    out_valid;
    result_t out_word;

    cfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .buffer_end (buffer_end),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_word     (q_in)
    );

    cfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_word (q_in),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_word (q_out)
    );

    cfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_word    (q_out),
        .q_pop     (q_pop),
        .pop       (pop),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

    // Present the output register
    assign empty        = !out_valid;
    assign is_status    = out_word.is_status;
    assign payload_byte = out_word.payload_byte;
    assign msg_type     = out_word.msg_type;
    assign status       = out_word.status;

endmodule

// ===== design/cfp_checker.sv =====
// Port-level checks for the frame parser, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cfp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       is_status,
    input logic [7:0] payload_byte,
    input logic [1:0] status
);

    // A waiting result that is not taken holds
    property p_hold_stalled;
        (!empty && !pop) |=>
            (!empty && $stable(is_status) && $stable(payload_byte) && $stable(status));
    endproperty

    // Result side shows nothing while in reset
    `ASSERT_ALWAYS(a_empty_in_reset, (!rst_n) |-> empty, "result shown during reset")

    // Hold a stalled result word
    `ASSERT_RUN(a_hold_stalled, p_hold_stalled, "stalled result changed")

    // Payload words carry a zero status code
    `ASSERT_ALWAYS(a_payload_status, (rst_n && !empty && !is_status) |-> (status == 2'd0), "payload word with nonzero status")

    // Status words carry a zero payload byte
    `ASSERT_ALWAYS(a_status_payload, (rst_n && !empty && is_status) |-> (payload_byte == 8'd0), "status word with nonzero payload")

endmodule

bind crc16_frame_parser_unit cfp_checker u_cfp_checker (.*);
